/* rtl/dcah_pkg.sv */
// Shared types, constant tables and ARX helper functions for the
// dual-chain ARX hash. No dependencies.
package dcah_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_PAD    = 12'b0000_0000_0010,
        S_CLOAD  = 12'b0000_0000_0100,
        S_EXPAND = 12'b0000_0000_1000,
        S_RLOAD  = 12'b0000_0001_0000,
        S_RQR    = 12'b0000_0010_0000,
        S_CROSS  = 12'b0000_0100_0000,
        S_EDGE   = 12'b0000_1000_0000,
        S_FFWD   = 12'b0001_0000_0000,
        S_FEDGE  = 12'b0010_0000_0000,
        S_OUT    = 12'b0100_0000_0000,
        S_SPARE  = 12'b1000_0000_0000
    } state_t;

    localparam word_t      GOLD_STEP = 32'h9E3779B9;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;

    localparam word_t PHI_K [16] = '{
        32'h9E37605A, 32'hDAC1E0F2, 32'hF287A338, 32'hFA8CFC04,
        32'hFD805AA6, 32'hCCF29760, 32'hFF8184C3, 32'hFF850D11,
        32'hCC32476B, 32'h98767486, 32'hFFF82080, 32'h30E4E2F3,
        32'hFCC3ACC1, 32'hE5216F38, 32'hF30E4CC9, 32'h948395F6
    };

    localparam word_t REC_K [16] = '{
        32'h7249217F, 32'h5890EB7C, 32'h4786B47C, 32'h4C51DBE8,
        32'h4E4DA61B, 32'h4F76650C, 32'h4F2F1A2A, 32'h4F6CE289,
        32'h4F1ADF40, 32'h4E84BABC, 32'h4F22D993, 32'h497FA704,
        32'h4F514F19, 32'h4E8F43B8, 32'h508E2FD9, 32'h4B5F94A4
    };

    localparam word_t INIT_G [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t INIT_C [8] = '{
        32'h9E3779B9, 32'h7F4A7C15, 32'hF39CC060, 32'h5CEDC834,
        32'h2FE12A6D, 32'h4786B47C, 32'hC8A5E2F0, 32'h3A8D6B7F
    };

    localparam logic [7:0] FIB_TAB [12] = '{
        8'd1, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd13, 8'd21, 8'd34, 8'd55, 8'd89, 8'd144
    };

    // (3i+5) mod 16 + 1
    localparam logic [4:0] FUSE_ROT [8] = '{
        5'd6, 5'd9, 5'd12, 5'd15, 5'd2, 5'd5, 5'd8, 5'd11
    };

    localparam logic [4:0] ROT_TAB [32][4] = '{
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd11, 5'd9, 5'd13, 5'd5},
        '{5'd8, 5'd16, 5'd7, 5'd12}, '{5'd16, 5'd7, 5'd12, 5'd8},
        '{5'd11, 5'd9, 5'd13, 5'd5}, '{5'd7, 5'd12, 5'd8, 5'd16},
        '{5'd11, 5'd9, 5'd13, 5'd5}, '{5'd12, 5'd8, 5'd16, 5'd7},
        '{5'd8, 5'd16, 5'd7, 5'd12}, '{5'd13, 5'd5, 5'd11, 5'd9},
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd7, 5'd12, 5'd8, 5'd16},
        '{5'd11, 5'd9, 5'd13, 5'd5}, '{5'd12, 5'd8, 5'd16, 5'd7},
        '{5'd9, 5'd13, 5'd5, 5'd11}, '{5'd16, 5'd7, 5'd12, 5'd8},
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd5, 5'd11, 5'd9, 5'd13},
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd11, 5'd9, 5'd13, 5'd5},
        '{5'd8, 5'd16, 5'd7, 5'd12}, '{5'd16, 5'd7, 5'd12, 5'd8},
        '{5'd11, 5'd9, 5'd13, 5'd5}, '{5'd7, 5'd12, 5'd8, 5'd16},
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd11, 5'd9, 5'd13, 5'd5},
        '{5'd8, 5'd16, 5'd7, 5'd12}, '{5'd13, 5'd5, 5'd11, 5'd9},
        '{5'd12, 5'd8, 5'd16, 5'd7}, '{5'd7, 5'd12, 5'd8, 5'd16},
        '{5'd11, 5'd9, 5'd13, 5'd5}, '{5'd12, 5'd8, 5'd16, 5'd7}
    };

    function automatic word_t rol(input word_t x, input logic [4:0] n);
        logic [63:0] t;
        t = {x, x} << n;
        return t[63:32];
    endfunction

    function automatic word_t ror(input word_t x, input logic [4:0] n);
        return rol(x, 5'(~n + 5'd1));
    endfunction

    // one ARX half-step: x += y; z = rol(z ^ x, r); returns {x, z}
    function automatic logic [63:0] arx(input word_t x, input word_t y,
                                        input word_t z, input logic [4:0] r);
        word_t xs;
        xs = x + y;
        return {xs, rol(z ^ xs, r)};
    endfunction

    function automatic word_t edge_k(input logic [5:0] rn);
        word_t k;
        unique case (rn)
            6'd7, 6'd31: k = 32'd21 * GOLD_STEP;
            6'd15:       k = 32'd3 * GOLD_STEP;
            6'd23:       k = 32'd144 * GOLD_STEP;
            6'd32:       k = 32'd34 * GOLD_STEP;
            6'd33:       k = 32'd55 * GOLD_STEP;
            default:     k = 32'd21 * GOLD_STEP;
        endcase
        return k;
    endfunction

    // edge protection on words 0 and 7; returns {s0, s7}
    function automatic logic [63:0] edge_fn(input word_t s0, input word_t s7,
                                            input word_t k);
        word_t a;
        word_t b;
        word_t mix;
        a   = ror(s0, 5'd7) ^ k;
        b   = rol(s7, 5'd13) ^ ~k;
        mix = (a ^ b) >> 16;
        return {a + mix, b + mix};
    endfunction

endpackage

/* rtl/dual_chain_arx_hash_256.sv */
// Dual-chain ARX hash, 256-bit digest, byte-serial stream in, word stream out.
// Uses dcah_pkg and one dcah_ram (message words and expanded schedule).
//
// Throughput: one byte per cycle while the block buffer fills. The 64th byte of a
// block starts a compression (load, schedule, rounds with cross and edge steps,
// feed-forward) over four ARX units and one RAM read port; s_tready is low
// meanwhile. A last beat pads byte by byte (one or two compressions), then fuses
// and emits 8 beats.
// Reset (rst_n, async low) loads the initial chains and clears counts; the
// message RAM is not cleared.
module dual_chain_arx_hash_256
    import dcah_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] byte_present
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
    output logic        m_tlast    // last_word
);

    state_t state_reg, state_next;

    word_t chain_g_reg [8];
    word_t chain_g_next [8];
    word_t chain_c_reg [8];
    word_t chain_c_next [8];
    word_t g_reg [8];
    word_t g_next [8];
    word_t c_reg [8];
    word_t c_next [8];

    logic [5:0]  fill_reg, fill_next;
    logic [60:0] len_reg, len_next;
    logic [60:0] len_inc;
    logic [63:0] lsr_reg, lsr_next;     // bit length, shifted out MSB first
    logic [23:0] acc_reg, acc_next;     // partial big-endian word
    logic        pad_act_reg, pad_act_next;
    logic        pad_first_reg, pad_first_next;
    logic        pad_len_reg, pad_len_next;
    logic        fin_reg, fin_next;     // compression ends the message

    logic [4:0]  r_reg, r_next;         // round
    logic [4:0]  ei_reg, ei_next;       // schedule word index
    logic [2:0]  cnt_reg, cnt_next;     // step within a state
    logic [3:0]  ra_reg, ra_next;       // 7 + i mod 5
    logic [3:0]  fib_reg, fib_next;     // i mod 12
    word_t       xacc_reg, xacc_next;

    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        out_last_reg, out_last_next;

    logic        ram_we;
    logic [4:0]  ram_waddr;
    word_t       ram_wdata;
    logic [4:0]  ram_raddr;
    word_t       ram_rdata;

    logic        push_en;
    logic [7:0]  push_byte;

    // quarter-round lane indices
    logic        diag, half;
    logic [2:0]  q0x, q0y, q0z, q1x, q1y, q1z;
    logic [4:0]  qrot;
    logic [63:0] g0_res, g1_res, c0_res, c1_res;

    logic [2:0]  cross_j;
    word_t       cross_t;
    logic [63:0] edge_g, edge_c;
    word_t       sig0, sig1;
    logic [4:0]  ra5, rb5;
    word_t       fuse_word;

    dcah_ram #(.WIDTH(32), .DEPTH(32)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_idx_reg, out_word_reg};
    assign m_tlast  = out_last_reg;

    assign len_inc = s_tuser ? 61'(len_reg + 61'd1) : len_reg;

    // ChaCha lane wiring: columns (0,1,2,3)(4,5,6,7), diagonals (0,5,2,7)(4,1,6,3)
    assign diag = cnt_reg[2];
    assign half = cnt_reg[0];
    assign qrot = ROT_TAB[r_reg][cnt_reg[1:0]];
    assign q0x  = half ? 3'd2 : 3'd0;
    assign q0y  = half ? (diag ? 3'd7 : 3'd3) : (diag ? 3'd5 : 3'd1);
    assign q0z  = half ? (diag ? 3'd5 : 3'd1) : (diag ? 3'd7 : 3'd3);
    assign q1x  = half ? 3'd6 : 3'd4;
    assign q1y  = half ? (diag ? 3'd3 : 3'd7) : (diag ? 3'd1 : 3'd5);
    assign q1z  = half ? (diag ? 3'd1 : 3'd5) : (diag ? 3'd3 : 3'd7);

    assign g0_res = arx(g_reg[q0x], g_reg[q0y], g_reg[q0z], qrot);
    assign g1_res = arx(g_reg[q1x], g_reg[q1y], g_reg[q1z], qrot);
    assign c0_res = arx(c_reg[q0x], c_reg[q0y], c_reg[q0z], qrot);
    assign c1_res = arx(c_reg[q1x], c_reg[q1y], c_reg[q1z], qrot);

    // cross step j reads c[j+3], which may already be updated
    assign cross_j = 3'(cnt_reg + 3'd3);
    assign cross_t = g_reg[cnt_reg] ^ c_reg[cross_j];

    // message schedule sigmas
    assign ra5  = {1'b0, ra_reg};
    assign rb5  = 5'(5'd17 + {3'd0, ei_reg[1:0]});
    assign sig0 = ror(ram_rdata, ra5) ^ ror(ram_rdata, 5'(ra5 + 5'd11)) ^ (ram_rdata >> 3);
    assign sig1 = ror(ram_rdata, rb5) ^ ror(ram_rdata, 5'(rb5 + 5'd2)) ^ (ram_rdata >> 10);

    // edge protection: rounds 8/16/24/32 inside, fixed 32 and 33 for the fuse
    assign edge_g = (state_reg == S_FEDGE)
                  ? edge_fn(chain_g_reg[0], chain_g_reg[7], edge_k(6'd32))
                  : edge_fn(g_reg[0], g_reg[7], edge_k({1'b0, r_reg}));
    assign edge_c = (state_reg == S_FEDGE)
                  ? edge_fn(chain_c_reg[0], chain_c_reg[7], edge_k(6'd33))
                  : edge_fn(c_reg[0], c_reg[7], edge_k({1'b0, r_reg}));

    assign fuse_word = (ror(g_reg[cnt_reg], FUSE_ROT[cnt_reg])
                      ^ rol(c_reg[cnt_reg], FUSE_ROT[cnt_reg])) + PHI_K[{1'b0, cnt_reg}];

    always_comb
    begin
        state_next     = state_reg;
        chain_g_next   = chain_g_reg;
        chain_c_next   = chain_c_reg;
        g_next         = g_reg;
        c_next         = c_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        lsr_next       = lsr_reg;
        acc_next       = acc_reg;
        pad_act_next   = pad_act_reg;
        pad_first_next = pad_first_reg;
        pad_len_next   = pad_len_reg;
        fin_next       = fin_reg;
        r_next         = r_reg;
        ei_next        = ei_reg;
        cnt_next       = cnt_reg;
        ra_next        = ra_reg;
        fib_next       = fib_reg;
        xacc_next      = xacc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = {1'b0, fill_reg[5:2]};
        ram_wdata      = {acc_reg, s_tdata};
        ram_raddr      = r_reg;
        push_en        = 1'b0;
        push_byte      = s_tdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        push_en  = 1'b1;
                        len_next = len_inc;
                    end
                    if (s_tlast)
                    begin
                        pad_act_next   = 1'b1;
                        pad_first_next = 1'b1;
                        pad_len_next   = 1'b0;
                        lsr_next       = {len_inc, 3'd0};
                    end
                    // a byte that fills the block compresses before any padding
                    if (s_tuser && fill_reg == 6'd63)
                    begin
                        fin_next   = 1'b0;
                        state_next = S_CLOAD;
                    end
                    else if (s_tlast)
                    begin
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                push_en = 1'b1;
                if (pad_first_reg)
                begin
                    push_byte = PAD_BYTE;
                end
                else if (pad_len_reg)
                begin
                    push_byte = lsr_reg[63:56];
                end
                else
                begin
                    push_byte = 8'd0;
                end
                pad_first_next = 1'b0;
                if (pad_len_reg)
                begin
                    lsr_next = lsr_reg << 8;
                end
                else if (6'(fill_reg + 6'd1) == LEN_POS)
                begin
                    pad_len_next = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    fin_next   = pad_len_reg;
                    state_next = S_CLOAD;
                end
            end

            S_CLOAD:
            begin
                g_next     = chain_g_reg;
                c_next     = chain_c_reg;
                ei_next    = 5'd16;
                cnt_next   = 3'd0;
                ra_next    = 4'd8;      // 7 + 16 mod 5
                fib_next   = 4'd4;      // 16 mod 12
                r_next     = 5'd0;
                state_next = S_EXPAND;
            end

            S_EXPAND:
            begin
                cnt_next = 3'(cnt_reg + 3'd1);
                unique case (cnt_reg)
                    3'd0: ram_raddr = 5'(ei_reg - 5'd16);
                    3'd1:
                    begin
                        ram_raddr = 5'(ei_reg - 5'd15);
                        xacc_next = ram_rdata;
                    end
                    3'd2:
                    begin
                        ram_raddr = 5'(ei_reg - 5'd7);
                        xacc_next = xacc_reg + sig0;
                    end
                    3'd3:
                    begin
                        ram_raddr = 5'(ei_reg - 5'd2);
                        xacc_next = xacc_reg + ram_rdata;
                    end
                    3'd4:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ei_reg;
                        ram_wdata = xacc_reg + sig1 + {24'd0, FIB_TAB[fib_reg]};
                        cnt_next  = 3'd0;
                        ei_next   = 5'(ei_reg + 5'd1);
                        ra_next   = (ra_reg == 4'd11) ? 4'd7 : 4'(ra_reg + 4'd1);
                        fib_next  = (fib_reg == 4'd11) ? 4'd0 : 4'(fib_reg + 4'd1);
                        if (ei_reg == 5'd31)
                        begin
                            state_next = S_RLOAD;
                        end
                    end
                    default: cnt_next = 3'd0;
                endcase
            end

            S_RLOAD:
            begin
                cnt_next = 3'(cnt_reg + 3'd1);
                unique case (cnt_reg)
                    3'd0: ram_raddr = r_reg;
                    3'd1:
                    begin
                        ram_raddr = ~r_reg;         // word 31 - r
                        g_next[0] = g_reg[0] + ram_rdata;
                        g_next[4] = g_reg[4] ^ PHI_K[r_reg[3:0]];
                    end
                    3'd2:
                    begin
                        c_next[0]  = c_reg[0] + ram_rdata;
                        c_next[4]  = c_reg[4] ^ REC_K[r_reg[3:0]];
                        cnt_next   = 3'd0;
                        state_next = S_RQR;
                    end
                    default: cnt_next = 3'd0;
                endcase
            end

            S_RQR:
            begin
                g_next[q0x] = g0_res[63:32];
                g_next[q0z] = g0_res[31:0];
                g_next[q1x] = g1_res[63:32];
                g_next[q1z] = g1_res[31:0];
                c_next[q0x] = c0_res[63:32];
                c_next[q0z] = c0_res[31:0];
                c_next[q1x] = c1_res[63:32];
                c_next[q1z] = c1_res[31:0];
                cnt_next    = 3'(cnt_reg + 3'd1);
                if (cnt_reg == 3'd7)
                begin
                    if (r_reg[1:0] == 2'd3)
                    begin
                        state_next = S_CROSS;
                    end
                    else
                    begin
                        r_next     = 5'(r_reg + 5'd1);
                        state_next = S_RLOAD;
                    end
                end
            end

            S_CROSS:
            begin
                g_next[cnt_reg] = g_reg[cnt_reg] + ror(cross_t, 5'd11);
                c_next[cnt_reg] = c_reg[cnt_reg] ^ rol(cross_t, 5'd11);
                cnt_next        = 3'(cnt_reg + 3'd1);
                if (cnt_reg == 3'd7)
                begin
                    if (r_reg[2:0] == 3'd7)
                    begin
                        state_next = S_EDGE;
                    end
                    else
                    begin
                        r_next     = 5'(r_reg + 5'd1);
                        state_next = S_RLOAD;
                    end
                end
            end

            S_EDGE:
            begin
                g_next[0] = edge_g[63:32];
                g_next[7] = edge_g[31:0];
                c_next[0] = edge_c[63:32];
                c_next[7] = edge_c[31:0];
                if (r_reg == 5'd31)
                begin
                    state_next = S_FFWD;
                end
                else
                begin
                    r_next     = 5'(r_reg + 5'd1);
                    state_next = S_RLOAD;
                end
            end

            S_FFWD:
            begin
                chain_g_next[cnt_reg] = chain_g_reg[cnt_reg] + g_reg[cnt_reg];
                chain_c_next[cnt_reg] = chain_c_reg[cnt_reg] + c_reg[cnt_reg];
                cnt_next              = 3'(cnt_reg + 3'd1);
                if (cnt_reg == 3'd7)
                begin
                    priority if (fin_reg)
                    begin
                        state_next = S_FEDGE;
                    end
                    else if (pad_act_reg)
                    begin
                        state_next = S_PAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FEDGE:
            begin
                g_next       = chain_g_reg;
                c_next       = chain_c_reg;
                g_next[0]    = edge_g[63:32];
                g_next[7]    = edge_g[31:0];
                c_next[0]    = edge_c[63:32];
                c_next[7]    = edge_c[31:0];
                pad_act_next = 1'b0;
                fin_next     = 1'b0;
                cnt_next     = 3'd0;
                state_next   = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = fuse_word;
                    out_idx_next   = cnt_reg;
                    out_last_next  = (cnt_reg == 3'd7);
                    cnt_next       = 3'(cnt_reg + 3'd1);
                    if (cnt_reg == 3'd7)
                    begin
                        chain_g_next = INIT_G;
                        chain_c_next = INIT_C;
                        fill_next    = 6'd0;
                        len_next     = 61'd0;
                        state_next   = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase

        // byte into the block buffer, a RAM word every fourth byte
        if (push_en)
        begin
            acc_next  = {acc_reg[15:0], push_byte};
            fill_next = 6'(fill_reg + 6'd1);
            if (fill_reg[1:0] == 2'd3)
            begin
                ram_we    = 1'b1;
                ram_waddr = {1'b0, fill_reg[5:2]};
                ram_wdata = {acc_reg, push_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chain_g_reg   <= INIT_G;
            chain_c_reg   <= INIT_C;
            fill_reg      <= '0;
            len_reg       <= '0;
            pad_act_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            pad_len_reg   <= 1'b0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_g_reg   <= chain_g_next;
            chain_c_reg   <= chain_c_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            pad_act_reg   <= pad_act_next;
            pad_first_reg <= pad_first_next;
            pad_len_reg   <= pad_len_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        c_reg        <= c_next;
        lsr_reg      <= lsr_next;
        acc_reg      <= acc_next;
        r_reg        <= r_next;
        ei_reg       <= ei_next;
        ra_reg       <= ra_next;
        fib_reg      <= fib_next;
        xacc_reg     <= xacc_next;
        out_word_reg <= out_word_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* rtl/dcah_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/dcah_checker.sv */
// Port-level checks for dual_chain_arx_hash_256, bound to the top level.
// Depends on the top level's port list only.
module dcah_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // stalled digest beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digest beat changed while stalled");

    // a waiting input beat is held by the sender
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=>
            s_tvalid && $stable(s_tdata) && $stable(s_tuser) && $stable(s_tlast))
        else $error("input beat changed while waiting");

    // tlast marks word seven and only it
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast does not match word index");

    // words follow in order without gaps
    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
        else $error("digest word index out of sequence");

    // input stays closed until the final digest word is up
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during digest output");

endmodule

bind dual_chain_arx_hash_256 dcah_checker u_dcah_checker (.*);

/* tb/dual_chain_arx_hash_256_test.sv */
// Self-checking testbench for dual_chain_arx_hash_256: byte stream in, digest words out.
// Depends on dcah_pkg (constants and tables) and the RTL top level.
// The digest is predicted in-bench for each accepted beat, and every output beat is checked.
module dual_chain_arx_hash_256_test
    import dcah_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0][31:0] chain_t;

    typedef struct {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
        bit         drain;      // hold this beat back until all digests are out
    } msg_beat_t;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    msg_beat_t    beat_queue[$];
    digest_beat_t digest_queue[$];

    // predicted hash state
    chain_t           gold_st;
    chain_t           comp_st;
    logic [63:0][7:0] blk_buf;
    int               blk_fill;
    logic [60:0]      byte_count;

    int  errors = 0;
    int  beats_taken = 0;
    int  words_seen = 0;
    int  digests_done = 0;
    int  blocks_done = 0;
    int  messages_queued = 0;
    bit  in_taken = 0;

    dual_chain_arx_hash_256 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        int k;
        k = n & 31;
        if (k == 0)
            return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return rotl(x, (32 - (n & 31)) & 31);
    endfunction

    function automatic chain_t quarter(input chain_t s, input int a, input int b,
                                       input int c, input int d, input int r);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], ROT_TAB[r][0]);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], ROT_TAB[r][1]);
        s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], ROT_TAB[r][2]);
        s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], ROT_TAB[r][3]);
        return s;
    endfunction

    function automatic chain_t guard_ends(input chain_t s, input int rn);
        logic [31:0] k;
        logic [31:0] mix;
        k    = 32'(FIB_TAB[rn % 12]) * GOLD_STEP;
        s[0] = rotr(s[0], 7) ^ k;
        s[7] = rotl(s[7], 13) ^ ~k;
        mix  = (s[0] ^ s[7]) >> 16;
        s[0] = s[0] + mix;
        s[7] = s[7] + mix;
        return s;
    endfunction

    function automatic chain_t all_rounds(input chain_t s, input int r);
        s = quarter(s, 0, 1, 2, 3, r);
        s = quarter(s, 4, 5, 6, 7, r);
        s = quarter(s, 0, 5, 2, 7, r);
        s = quarter(s, 4, 1, 6, 3, r);
        return s;
    endfunction

    task automatic compress_block();
        logic [31:0] w[32];
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] t;
        chain_t      g;
        chain_t      c;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 32; i++)
        begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + w[i-7] + 32'(FIB_TAB[i % 12])
                 + (rotr(x, 7 + i % 5) ^ rotr(x, 18 + i % 5) ^ (x >> 3))
                 + (rotr(y, 17 + i % 4) ^ rotr(y, 19 + i % 4) ^ (y >> 10));
        end
        g = gold_st;
        c = comp_st;
        for (int r = 0; r < 32; r++)
        begin
            g[0] = g[0] + w[r];
            c[0] = c[0] + w[31-r];
            g[4] = g[4] ^ PHI_K[r & 15];
            c[4] = c[4] ^ REC_K[r & 15];
            g = all_rounds(g, r);
            c = all_rounds(c, r);
            if (((r + 1) & 3) == 0)
            begin
                // cross-chain diffusion, in place word by word
                for (int i = 0; i < 8; i++)
                begin
                    t    = g[i] ^ c[(i + 3) & 7];
                    g[i] = g[i] + rotr(t, 11);
                    c[i] = c[i] ^ rotl(t, 11);
                end
            end
            if (((r + 1) & 7) == 0)
            begin
                g = guard_ends(g, r);
                c = guard_ends(c, r);
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            gold_st[i] = gold_st[i] + g[i];
            comp_st[i] = comp_st[i] + c[i];
        end
        blocks_done++;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            gold_st[i] = INIT_G[i];
            comp_st[i] = INIT_C[i];
        end
        blk_fill   = 0;
        byte_count = '0;
    endtask

    // one accepted input beat: absorb, and on last pad and queue the digest
    task automatic absorb_beat(input logic [7:0] b, input logic present, input logic fin);
        logic [63:0]  bits;
        chain_t       g;
        chain_t       c;
        digest_beat_t d;
        int           rot;
        if (present)
        begin
            blk_buf[blk_fill] = b;
            blk_fill   = (blk_fill + 1) & 63;
            byte_count = byte_count + 1'b1;
            if (blk_fill == 0)
                compress_block();
        end
        if (!fin)
            return;
        blk_buf[blk_fill] = PAD_BYTE;
        blk_fill = blk_fill + 1;
        if (blk_fill > 56)
        begin
            for (int i = blk_fill; i < 64; i++)
                blk_buf[i] = 8'h00;
            compress_block();
            blk_fill = 0;
        end
        for (int i = blk_fill; i < 56; i++)
            blk_buf[i] = 8'h00;
        bits = {byte_count, 3'b000};
        for (int i = 0; i < 8; i++)
            blk_buf[56+i] = bits[63 - 8*i -: 8];
        compress_block();
        g = guard_ends(gold_st, 32);
        c = guard_ends(comp_st, 33);
        for (int i = 0; i < 8; i++)
        begin
            rot = (i * 3 + 5) % 16 + 1;
            d.digest_word = (rotr(g[i], rot) ^ rotl(c[i], rot)) + PHI_K[i];
            d.word_index  = 3'(i);
            d.last_word   = (i == 7);
            digest_queue.push_back(d);
        end
        digests_done++;
        restart_hash();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h (word %0d)", what, got, want, words_seen);
        errors++;
    endtask

    task automatic push_beat(input logic [7:0] b, input logic present, input logic fin,
                             input bit drain);
        msg_beat_t m;
        m.data_byte    = b;
        m.byte_present = present;
        m.last         = fin;
        m.drain        = drain;
        beat_queue.push_back(m);
    endtask

    // message of len bytes; ends with last on the final byte or with a bare finish
    task automatic queue_message(input int len, input bit bare, input bit drain);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 4)
                push_beat(8'($urandom), 1'b0, 1'b0, 1'b0);   // ignored beat
            push_beat(8'($urandom), 1'b1, (i == len - 1) && !bare, drain && i == 0);
        end
        if (bare || len == 0)
            push_beat(8'($urandom), 1'b0, 1'b1, drain && len == 0);
        messages_queued++;
    endtask

    // monitor: input acceptance feeds the predictor, output beats are checked
    always @(posedge clk)
    begin
        digest_beat_t d;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                in_taken = 1;
                beats_taken++;
                absorb_beat(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (digest_queue.size() == 0)
                    report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
                else
                begin
                    d = digest_queue.pop_front();
                    if (m_tdata[31:0] !== d.digest_word)
                        report_mismatch("digest_word", m_tdata[31:0], d.digest_word);
                    if (m_tdata[34:32] !== d.word_index)
                        report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(d.word_index));
                    if (m_tlast !== d.last_word)
                        report_mismatch("last_word", 32'(m_tlast), 32'(d.last_word));
                    if (m_tdata[39:35] !== 5'd0)
                        report_mismatch("fill bits", 32'(m_tdata[39:35]), 32'h0);
                end
                words_seen++;
            end
        end
    end

    // driver: new beats and ready change on the falling edge
    always @(negedge clk)
    begin
        msg_beat_t m;
        bit        quiet;
        if (rst_n)
        begin
            quiet = (beats_taken >= 30 && beats_taken < 90);
            if (!s_tvalid || in_taken)
            begin
                in_taken = 0;
                if (beat_queue.size() > 0
                    && !(beat_queue[0].drain && digest_queue.size() != 0)
                    && (quiet || $urandom_range(99) >= 9))
                begin
                    m = beat_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= m.data_byte;
                    s_tuser  <= m.byte_present;
                    s_tlast  <= m.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    initial
    begin
        int boundary[7];
        int msg_no;
        boundary = '{55, 56, 57, 63, 64, 119, 0};
        restart_hash();
        blk_buf = '0;

        // directed: empty message, 0xFF with last, ignored beats, 0x00 0xA5 + bare finish
        push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b1, 1'b1, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b1, 1'b0, 1'b0);
        push_beat(8'hA5, 1'b1, 1'b0, 1'b0);
        push_beat(8'h5A, 1'b0, 1'b1, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h7E, 1'b1, 1'b1, 1'b1);

        // random messages, padding boundaries hit often
        msg_no = 0;
        while (beat_queue.size() < 150)
        begin
            if ($urandom_range(9) < 3)
                queue_message(boundary[$urandom_range(6)], $urandom_range(1), msg_no == 3);
            else
                queue_message($urandom_range(24), $urandom_range(1), msg_no == 3);
            msg_no++;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the final beat is on the bus by the next rising edge; wait for its acceptance
        wait (beat_queue.size() == 0);
        @(posedge clk);
        wait (!s_tvalid);
        wait (digest_queue.size() == 0);
        repeat (1200) @(posedge clk);

        $display("Covered %0d input beats, %0d messages, %0d blocks, %0d digests (%0d words)",
                 beats_taken, messages_queued + 4, blocks_done, digests_done, words_seen);
        if (errors == 0 && digest_queue.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout: %0d digest words still pending", digest_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
